>>> rtl/core/wfls_pkg.sv
`default_nettype none

package wfls_pkg;

    // Milliseconds in one second, used to scale the sampling intervals.
    localparam int unsigned MS_PER_S = 1000;

    localparam int unsigned INTERVAL_W  = 16;
    localparam int unsigned INTERVAL_MS_W = 26;
    localparam int unsigned TOLERANCE_W = 20;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [INTERVAL_W-1:0]  IDLE_INTERVAL_RESET     = 16'd10;
    localparam logic [INTERVAL_W-1:0]  WATERING_INTERVAL_RESET = 16'd10;
    localparam logic [TOLERANCE_W-1:0] TOLERANCE_RESET         = 20'd100;
    localparam logic [WORD_W-1:0]      LEAK_DELAY_RESET        = 32'd10000;
    localparam logic [WORD_W-1:0]      NOFLOW_DELAY_RESET      = 32'd10000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IDLE_INTERVAL     = 3'd0,
        CFG_WATERING_INTERVAL = 3'd1,
        CFG_TOLERANCE         = 3'd2,
        CFG_LEAK_DELAY        = 3'd3,
        CFG_NOFLOW_DELAY      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0]  idle_interval_s;
        logic [INTERVAL_W-1:0]  watering_interval_s;
        logic [TOLERANCE_W-1:0] tolerance_ml;
        logic [WORD_W-1:0]      leak_error_delay_ms;
        logic [WORD_W-1:0]      noflow_error_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] now_ms;
        logic              main_present;
        logic              valve_open;
        logic [WORD_W-1:0] main_ml;
        logic [WORD_W-1:0] leaf_ml;
    } tick_t;

    typedef struct packed {
        logic              close_all;
        logic              leak_warn;
        logic              leak_error;
        logic              noflow_error;
        logic [WORD_W-1:0] unaccounted_ml;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/water_flow_leak_supervisor.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// s_        in         s_valid / s_ready       now_ms, main_present, valve_open, main_ml, leaf_ml
// m_        out        m_valid / m_ready       close_all, leak_warn, leak_error, noflow_error,
//                                              unaccounted_ml
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One tick is taken every clock cycle while s_ready is high. A tick is held in the input register and is
// evaluated on its way into the result register, from which its result is presented until
// it is transferred. Synchronous reset clears the detector state and restores the register
// defaults.
// A stalled result register holds its contents while the input register still takes one more
// tick; only when both are full does s_ready fall.

module water_flow_leak_supervisor
    import wfls_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [WORD_W-1:0]       s_now_ms,
    input  wire logic                    s_main_present,
    input  wire logic                    s_valve_open,
    input  wire logic [WORD_W-1:0]       s_main_ml,
    input  wire logic [WORD_W-1:0]       s_leaf_ml,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_close_all,
    output logic                         m_leak_warn,
    output logic                         m_leak_error,
    output logic                         m_noflow_error,
    output logic signed [WORD_W-1:0]     m_unaccounted_ml,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [WORD_W-1:0]       cfg_data
);

    cfg_t    cfg_reg;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;
    result_t res_next;
    logic    advance;

    // The register file is always ready; writes to an index beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_interval_s       <= IDLE_INTERVAL_RESET;
            cfg_reg.watering_interval_s   <= WATERING_INTERVAL_RESET;
            cfg_reg.tolerance_ml          <= TOLERANCE_RESET;
            cfg_reg.leak_error_delay_ms   <= LEAK_DELAY_RESET;
            cfg_reg.noflow_error_delay_ms <= NOFLOW_DELAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_IDLE_INTERVAL:     cfg_reg.idle_interval_s <= cfg_data[INTERVAL_W-1:0];
                CFG_WATERING_INTERVAL: cfg_reg.watering_interval_s <= cfg_data[INTERVAL_W-1:0];
                CFG_TOLERANCE:         cfg_reg.tolerance_ml <= cfg_data[TOLERANCE_W-1:0];
                CFG_LEAK_DELAY:        cfg_reg.leak_error_delay_ms <= cfg_data;
                CFG_NOFLOW_DELAY:      cfg_reg.noflow_error_delay_ms <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The tick in the input register moves on whenever the result register is free or
    // its contents are being transferred out in the same cycle.
    assign advance = tick_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !tick_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg <= 1'b0;
        end else if (s_ready) begin
            tick_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tick_reg.now_ms       <= s_now_ms;
            tick_reg.main_present <= s_main_present;
            tick_reg.valve_open   <= s_valve_open;
            tick_reg.main_ml      <= s_main_ml;
            tick_reg.leaf_ml      <= s_leaf_ml;
        end
    end

    // Both detectors and their state live here; state moves only when a tick advances,
    // so each tick sees exactly what the previous one left behind.
    wfls_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .tick    (tick_reg),
        .cfg     (cfg_reg),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = res_valid_reg;
    assign m_close_all      = res_reg.close_all;
    assign m_leak_warn      = res_reg.leak_warn;
    assign m_leak_error     = res_reg.leak_error;
    assign m_noflow_error   = res_reg.noflow_error;
    assign m_unaccounted_ml = $signed(res_reg.unaccounted_ml);

endmodule

`default_nettype wire

>>> rtl/core/wfls_eval.sv
`default_nettype none

module wfls_eval
    import wfls_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire tick_t   tick,
    input  wire cfg_t    cfg,
    output result_t      res
);

    logic [WORD_W-1:0] leak_last_check_reg,   leak_last_check_next;
    logic [WORD_W-1:0] leak_last_main_reg,    leak_last_main_next;
    logic [WORD_W-1:0] leak_last_leaf_reg,    leak_last_leaf_next;
    logic              leak_detected_reg,     leak_detected_next;
    logic              leak_reported_reg,     leak_reported_next;
    logic              watering_happened_reg, watering_happened_next;
    logic [WORD_W-1:0] leak_detect_time_reg,  leak_detect_time_next;
    logic [WORD_W-1:0] noflow_last_check_reg, noflow_last_check_next;
    logic [WORD_W-1:0] noflow_last_main_reg,  noflow_last_main_next;
    logic              noflow_detected_reg,   noflow_detected_next;
    logic              noflow_reported_reg,   noflow_reported_next;
    logic [WORD_W-1:0] noflow_detect_time_reg, noflow_detect_time_next;

    logic [INTERVAL_MS_W-1:0] idle_ms;
    logic [INTERVAL_MS_W-1:0] watering_ms;
    logic [WORD_W-1:0]        leak_elapsed;
    logic [WORD_W-1:0]        noflow_elapsed;
    logic [WORD_W-1:0]        leak_diff;
    logic [WORD_W-1:0]        noflow_used;
    logic signed [WORD_W-1:0] tol_s;

    logic              close_all_c;
    logic              leak_warn_c;
    logic              leak_error_c;
    logic              noflow_error_c;
    logic [WORD_W-1:0] unaccounted_c;

    assign idle_ms = INTERVAL_MS_W'(cfg.idle_interval_s) * INTERVAL_MS_W'(MS_PER_S);
    assign watering_ms = INTERVAL_MS_W'(cfg.watering_interval_s) * INTERVAL_MS_W'(MS_PER_S);
    assign leak_elapsed   = tick.now_ms - leak_last_check_reg;
    assign noflow_elapsed = tick.now_ms - noflow_last_check_reg;
    assign leak_diff   = (tick.main_ml - leak_last_main_reg)
                       - (tick.leaf_ml - leak_last_leaf_reg);
    assign noflow_used = tick.main_ml - noflow_last_main_reg;
    assign tol_s = $signed({{(WORD_W-TOLERANCE_W){1'b0}}, cfg.tolerance_ml});

    assign res = {close_all_c, leak_warn_c, leak_error_c, noflow_error_c, unaccounted_c};

    // Leak detector: samples only with a main meter present and all valves shut.
    always_comb begin
        leak_last_check_next   = leak_last_check_reg;
        leak_last_main_next    = leak_last_main_reg;
        leak_last_leaf_next    = leak_last_leaf_reg;
        leak_detected_next     = leak_detected_reg;
        leak_reported_next     = leak_reported_reg;
        watering_happened_next = watering_happened_reg;
        leak_detect_time_next  = leak_detect_time_reg;
        close_all_c   = 1'b0;
        leak_warn_c   = 1'b0;
        leak_error_c  = 1'b0;
        unaccounted_c = '0;
        if (!tick.main_present) begin
            leak_detected_next = 1'b0;
            leak_reported_next = 1'b0;
        end else if (tick.valve_open) begin
            leak_detected_next     = 1'b0;
            leak_reported_next     = 1'b0;
            watering_happened_next = 1'b1;
        end else if (leak_elapsed >= WORD_W'(idle_ms)) begin
            leak_last_check_next = tick.now_ms;
            leak_last_main_next  = tick.main_ml;
            leak_last_leaf_next  = tick.leaf_ml;
            unaccounted_c        = leak_diff;
            if (watering_happened_reg || ($signed(leak_diff) <= tol_s)) begin
                watering_happened_next = 1'b0;
                leak_detected_next     = 1'b0;
                leak_reported_next     = 1'b0;
            end else if (!leak_detected_reg) begin
                close_all_c           = 1'b1;
                leak_warn_c           = 1'b1;
                leak_detect_time_next = tick.now_ms;
                leak_detected_next    = 1'b1;
            end else if (!leak_reported_reg &&
                         ((tick.now_ms - leak_detect_time_reg) >=
                          cfg.leak_error_delay_ms)) begin
                leak_error_c       = 1'b1;
                leak_reported_next = 1'b1;
            end
        end
    end

    // No-flow detector: open valves while the main meter stays within tolerance.
    always_comb begin
        noflow_last_check_next  = noflow_last_check_reg;
        noflow_last_main_next   = noflow_last_main_reg;
        noflow_detected_next    = noflow_detected_reg;
        noflow_reported_next    = noflow_reported_reg;
        noflow_detect_time_next = noflow_detect_time_reg;
        noflow_error_c          = 1'b0;
        if (!tick.main_present) begin
            noflow_detected_next = 1'b0;
            noflow_reported_next = 1'b0;
        end else if (noflow_elapsed >= WORD_W'(watering_ms)) begin
            noflow_last_check_next = tick.now_ms;
            noflow_last_main_next  = tick.main_ml;
            if (!tick.valve_open || ($signed(noflow_used) > tol_s)) begin
                noflow_detected_next = 1'b0;
                noflow_reported_next = 1'b0;
            end else if (!noflow_detected_reg) begin
                noflow_detect_time_next = tick.now_ms;
                noflow_detected_next    = 1'b1;
            end else if (!noflow_reported_reg &&
                         ((tick.now_ms - noflow_detect_time_reg) >=
                          cfg.noflow_error_delay_ms)) begin
                noflow_error_c       = 1'b1;
                noflow_reported_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leak_last_check_reg    <= '0;
            leak_last_main_reg     <= '0;
            leak_last_leaf_reg     <= '0;
            leak_detected_reg      <= 1'b0;
            leak_reported_reg      <= 1'b0;
            watering_happened_reg  <= 1'b0;
            leak_detect_time_reg   <= '0;
            noflow_last_check_reg  <= '0;
            noflow_last_main_reg   <= '0;
            noflow_detected_reg    <= 1'b0;
            noflow_reported_reg    <= 1'b0;
            noflow_detect_time_reg <= '0;
        end else if (en) begin
            leak_last_check_reg    <= leak_last_check_next;
            leak_last_main_reg     <= leak_last_main_next;
            leak_last_leaf_reg     <= leak_last_leaf_next;
            leak_detected_reg      <= leak_detected_next;
            leak_reported_reg      <= leak_reported_next;
            watering_happened_reg  <= watering_happened_next;
            leak_detect_time_reg   <= leak_detect_time_next;
            noflow_last_check_reg  <= noflow_last_check_next;
            noflow_last_main_reg   <= noflow_last_main_next;
            noflow_detected_reg    <= noflow_detected_next;
            noflow_reported_reg    <= noflow_reported_next;
            noflow_detect_time_reg <= noflow_detect_time_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
    import wfls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index seven is not decoded by the block, so a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX = 3'd7;

    // Cycles for which the result side refuses transfers in the back-pressure test.
    localparam int HOLDOFF_CYCLES = 64;

    // Behaviour of the synthetic plant between two ticks.
    typedef enum int {
        QUIET,
        LEAKING,
        WATERING,
        DRY_RUN
    } flow_phase_t;

    // Our own mirror of the detector state.
    typedef struct packed {
        logic [WORD_W-1:0] leak_check_ms, leak_main_ml, leak_leaf_ml, leak_seen_ms;
        logic              leak_seen, leak_raised, watered;
        logic [WORD_W-1:0] dry_check_ms, dry_main_ml, dry_seen_ms;
        logic              dry_seen, dry_raised;
    } detector_state_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [WORD_W-1:0]        s_now_ms = '0;
    logic                     s_main_present = 1'b0;
    logic                     s_valve_open = 1'b0;
    logic [WORD_W-1:0]        s_main_ml = '0;
    logic [WORD_W-1:0]        s_leaf_ml = '0;

    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_close_all;
    logic                     m_leak_warn;
    logic                     m_leak_error;
    logic                     m_noflow_error;
    logic signed [WORD_W-1:0] m_unaccounted_ml;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [WORD_W-1:0]        cfg_data = '0;

    // Register copy and detector state as the supervisor should hold them.
    cfg_t            mirror_cfg = {IDLE_INTERVAL_RESET, WATERING_INTERVAL_RESET,
                                   TOLERANCE_RESET, LEAK_DELAY_RESET, NOFLOW_DELAY_RESET};
    detector_state_t det = '0;

    // Verdicts that have been predicted but not yet seen on the result channel, oldest first.
    result_t awaited_verdicts[$];
    int      mismatches = 0;

    // Test control shared with the free-running result sink.
    bit steady_mode = 1'b0;
    bit holdoff_request = 1'b0;

    // Running totals of the synthetic plant used to build well-formed tick sequences.
    logic [WORD_W-1:0] flow_now = '0;
    logic [WORD_W-1:0] flow_main = '0;
    logic [WORD_W-1:0] flow_leaf = '0;

    water_flow_leak_supervisor dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_now_ms         (s_now_ms),
        .s_main_present   (s_main_present),
        .s_valve_open     (s_valve_open),
        .s_main_ml        (s_main_ml),
        .s_leaf_ml        (s_leaf_ml),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_close_all      (m_close_all),
        .m_leak_warn      (m_leak_warn),
        .m_leak_error     (m_leak_error),
        .m_noflow_error   (m_noflow_error),
        .m_unaccounted_ml (m_unaccounted_ml),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Runs one tick through both detectors, updating the mirrored state, and returns the
    // verdict the block should produce for it. All differences wrap at 32 bits; the volume differences
    // are then read as two's complement before they are compared with the tolerance.
    function automatic result_t supervise_tick(input tick_t t);
        result_t           v;
        logic [WORD_W-1:0] leak_span_ms, dry_span_ms, diff, used;
        int                tol;
        v = '0;
        tol = int'(mirror_cfg.tolerance_ml);
        leak_span_ms = 32'(mirror_cfg.idle_interval_s) * MS_PER_S;
        dry_span_ms = 32'(mirror_cfg.watering_interval_s) * MS_PER_S;

        // Leak detector: only samples while the meter exists and every valve is shut.
        if (!t.main_present) begin
            det.leak_seen = 1'b0;
            det.leak_raised = 1'b0;
        end else if (t.valve_open) begin
            det.leak_seen = 1'b0;
            det.leak_raised = 1'b0;
            det.watered = 1'b1;
        end else if (WORD_W'(t.now_ms - det.leak_check_ms) >= leak_span_ms) begin
            diff = WORD_W'(t.main_ml - det.leak_main_ml)
                 - WORD_W'(t.leaf_ml - det.leak_leaf_ml);
            det.leak_check_ms = t.now_ms;
            det.leak_main_ml = t.main_ml;
            det.leak_leaf_ml = t.leaf_ml;
            v.unaccounted_ml = diff;
            // The first sample after watering only re-bases the totals.
            if (det.watered || $signed(diff) <= tol) begin
                det.watered = 1'b0;
                det.leak_seen = 1'b0;
                det.leak_raised = 1'b0;
            end else if (!det.leak_seen) begin
                v.close_all = 1'b1;
                v.leak_warn = 1'b1;
                det.leak_seen_ms = t.now_ms;
                det.leak_seen = 1'b1;
            end else if (!det.leak_raised &&
                         WORD_W'(t.now_ms - det.leak_seen_ms) >=
                         mirror_cfg.leak_error_delay_ms) begin
                v.leak_error = 1'b1;
                det.leak_raised = 1'b1;
            end
        end

        // No-flow detector: open valves but the main meter barely moves.
        if (!t.main_present) begin
            det.dry_seen = 1'b0;
            det.dry_raised = 1'b0;
        end else if (WORD_W'(t.now_ms - det.dry_check_ms) >= dry_span_ms) begin
            used = t.main_ml - det.dry_main_ml;
            det.dry_check_ms = t.now_ms;
            det.dry_main_ml = t.main_ml;
            if (!t.valve_open || $signed(used) > tol) begin
                det.dry_seen = 1'b0;
                det.dry_raised = 1'b0;
            end else if (!det.dry_seen) begin
                det.dry_seen_ms = t.now_ms;
                det.dry_seen = 1'b1;
            end else if (!det.dry_raised &&
                         WORD_W'(t.now_ms - det.dry_seen_ms) >=
                         mirror_cfg.noflow_error_delay_ms) begin
                v.noflow_error = 1'b1;
                det.dry_raised = 1'b1;
            end
        end
        return v;
    endfunction

    // Watches all three channels at each rising edge. Register writes update the mirrored
    // configuration, every accepted tick is predicted at once, and every result transfer is
    // checked against the oldest prediction still waiting.
    always @(posedge aclk) begin
        tick_t   tick;
        result_t got, want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IDLE_INTERVAL: begin
                        mirror_cfg.idle_interval_s = cfg_data[INTERVAL_W-1:0];
                    end
                    CFG_WATERING_INTERVAL: begin
                        mirror_cfg.watering_interval_s = cfg_data[INTERVAL_W-1:0];
                    end
                    CFG_TOLERANCE: begin
                        mirror_cfg.tolerance_ml = cfg_data[TOLERANCE_W-1:0];
                    end
                    CFG_LEAK_DELAY: begin
                        mirror_cfg.leak_error_delay_ms = cfg_data;
                    end
                    CFG_NOFLOW_DELAY: begin
                        mirror_cfg.noflow_error_delay_ms = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                tick.now_ms = s_now_ms;
                tick.main_present = s_main_present;
                tick.valve_open = s_valve_open;
                tick.main_ml = s_main_ml;
                tick.leaf_ml = s_leaf_ml;
                awaited_verdicts.push_back(supervise_tick(tick));
            end
            if (m_valid && m_ready) begin
                got.close_all = m_close_all;
                got.leak_warn = m_leak_warn;
                got.leak_error = m_leak_error;
                got.noflow_error = m_noflow_error;
                got.unaccounted_ml = m_unaccounted_ml;
                if (awaited_verdicts.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result transfer with no tick outstanding", $realtime);
                    end
                    mismatches++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display({"%0t: verdict mismatch: expected close=%0b warn=%0b ",
                                      "lerr=%0b nerr=%0b unacc=%0d, got close=%0b warn=%0b ",
                                      "lerr=%0b nerr=%0b unacc=%0d"},
                                     $realtime, want.close_all, want.leak_warn, want.leak_error,
                                     want.noflow_error, $signed(want.unaccounted_ml),
                                     got.close_all, got.leak_warn, got.leak_error,
                                     got.noflow_error, $signed(got.unaccounted_ml));
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result sink. Ready is dropped at random with a chance of 8 in 100, never while the steady
    // mode is on, and for a long counted stretch whenever a test asks for a hold-off.
    initial begin : result_sink
        int held;
        forever begin
            @(posedge aclk);
            if (holdoff_request) begin
                holdoff_request = 1'b0;
                m_ready <= 1'b0;
                for (held = 0; held < HOLDOFF_CYCLES; held++) begin
                    @(posedge aclk);
                end
            end
            m_ready <= steady_mode || ($urandom_range(99) >= 8);
        end
    end

    // Offers one tick and returns at the edge where it is transferred. Valid stays high when
    // the next tick follows directly, so it is never lowered and raised within one step.
    task automatic send_tick(input logic [WORD_W-1:0] now_ms, input logic present,
                             input logic open, input logic [WORD_W-1:0] main_ml,
                             input logic [WORD_W-1:0] leaf_ml);
        while (!steady_mode && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_now_ms <= now_ms;
        s_main_present <= present;
        s_valve_open <= open;
        s_main_ml <= main_ml;
        s_leaf_ml <= leaf_ml;
        do @(posedge aclk); while (!s_ready);
    endtask

    // The extra edge after each write keeps the valid of back-to-back writes apart.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops offering ticks and waits until every predicted verdict has come back, then lets
    // the two pipeline stages settle. The first edge makes sure the prediction for the last
    // transfer has been queued before the queue is looked at.
    task automatic await_verdicts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_all_registers(input logic [WORD_W-1:0] idle_s,
                                       input logic [WORD_W-1:0] watering_s,
                                       input logic [WORD_W-1:0] tol_ml,
                                       input logic [WORD_W-1:0] leak_delay,
                                       input logic [WORD_W-1:0] dry_delay);
        write_register(CFG_IDLE_INTERVAL, idle_s);
        write_register(CFG_WATERING_INTERVAL, watering_s);
        write_register(CFG_TOLERANCE, tol_ml);
        write_register(CFG_LEAK_DELAY, leak_delay);
        write_register(CFG_NOFLOW_DELAY, dry_delay);
    endtask

    // Drives a plausible plant: phases of quiet, leaking, watering and valves open with no
    // flow, with the meter sometimes missing. Time steps scale with the sampling intervals so
    // that samples land on both sides of the interval. About one tick in ten is pure noise.
    task automatic run_flow(input int count);
        int unsigned span, tol_u, shared, step, longest_s;
        int          phase_left;
        flow_phase_t phase;
        bit          present;
        phase_left = 0;
        phase = QUIET;
        present = 1'b1;
        tol_u = 32'(mirror_cfg.tolerance_ml);
        longest_s = 32'((mirror_cfg.idle_interval_s > mirror_cfg.watering_interval_s) ?
                        mirror_cfg.idle_interval_s : mirror_cfg.watering_interval_s);
        span = 2 * MS_PER_S * longest_s;
        if (span == 0) begin
            span = 2 * MS_PER_S;
        end
        for (int i = 0; i < count; i++) begin
            if (phase_left == 0) begin
                phase = flow_phase_t'($urandom_range(0, 3));
                phase_left = $urandom_range(3, 24);
                present = ($urandom_range(0, 15) != 0);
            end
            phase_left--;
            if ($urandom_range(99) < 10) begin
                send_tick($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom, $urandom);
                continue;
            end
            step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, span);
            flow_now += step;
            shared = $urandom_range(0, 400);
            case (phase)
                QUIET: begin
                    // Now and then the leaf meters run ahead, giving a negative difference.
                    flow_main += shared;
                    flow_leaf += shared;
                    if ($urandom_range(0, 3) == 0) begin
                        flow_leaf += $urandom_range(0, tol_u + 50);
                    end
                end
                LEAKING: begin
                    flow_main += shared + $urandom_range(0, 2 * tol_u + 200);
                    flow_leaf += shared;
                end
                WATERING: begin
                    flow_main += tol_u + shared + 1;
                    flow_leaf += tol_u + shared + 1;
                end
                DRY_RUN: begin
                    flow_main += $urandom_range(0, tol_u);
                end
                default: begin
                end
            endcase
            send_tick(flow_now, present, (phase == WATERING) || (phase == DRY_RUN), flow_main,
                      flow_leaf);
        end
    endtask

    // Hand-picked ticks: a leak with its warning and later error, a missing meter, open valves
    // with no flow up to the error, the re-basing sample after watering, a negative difference,
    // zero intervals with zero delays, wrap of time and totals, and the register extremes.
    task automatic test_directed_cases();
        send_tick(32'd10000, 1'b1, 1'b0, 32'd500, 32'd0);
        send_tick(32'd20000, 1'b1, 1'b0, 32'd1000, 32'd0);
        send_tick(32'd25000, 1'b0, 1'b1, 32'd7, 32'd3);
        send_tick(32'd30000, 1'b1, 1'b1, 32'd0, 32'd0);
        send_tick(32'd40000, 1'b1, 1'b1, 32'd0, 32'd0);
        send_tick(32'd50000, 1'b1, 1'b0, 32'd5000, 32'd0);
        send_tick(32'd60000, 1'b1, 1'b0, 32'd4000, 32'd9000);
        await_verdicts();

        write_all_registers(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        write_register(SPARE_INDEX, 32'hFFFF_FFFF);
        send_tick(32'd60001, 1'b1, 1'b0, 32'd4001, 32'd9000);
        send_tick(32'd60001, 1'b1, 1'b0, 32'd4002, 32'd9000);
        send_tick(32'd60002, 1'b1, 1'b1, 32'd4002, 32'd9000);
        send_tick(32'd60002, 1'b1, 1'b1, 32'd4002, 32'd9000);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0);
        send_tick(32'd5, 1'b1, 1'b0, 32'h0000_0010, 32'd0);
        await_verdicts();

        write_all_registers(32'd65535, 32'd65535, 32'd1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(32'h8000_0000, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'd0);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF);
        send_tick(32'h0000_0000, 1'b1, 1'b0, 32'h8000_0000, 32'd0);
        await_verdicts();
    endtask

    // Several rounds of plant behaviour, each under a fresh register setting. One round zeroes
    // the tolerance and delays, another runs at the widest intervals and a tolerance of 1000000 ml.
    task automatic test_random_flow();
        for (int round = 0; round < 6; round++) begin
            case (round)
                2: write_all_registers(32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
                4: write_all_registers(32'd65535, 32'd65535, 32'd1000000,
                                       $urandom, $urandom);
                default: write_all_registers($urandom_range(0, 4), $urandom_range(0, 4),
                                             $urandom_range(0, 1500), $urandom_range(0, 15000),
                                             $urandom_range(0, 15000));
            endcase
            flow_main = $urandom;
            flow_leaf = $urandom;
            run_flow(270);
            await_verdicts();
        end
    endtask

    // Neither side idles, so ticks go through at the full rate of one per clock.
    task automatic test_back_to_back();
        write_all_registers($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 800),
                            $urandom_range(0, 6000), $urandom_range(0, 6000));
        steady_mode = 1'b1;
        run_flow(200);
        await_verdicts();
        steady_mode = 1'b0;
    endtask

    // The sink holds off long enough for both stages to fill and the input to stall while
    // ticks keep being offered. Afterwards the source pauses until every verdict is back.
    task automatic test_output_stall();
        holdoff_request = 1'b1;
        run_flow(30);
        await_verdicts();
        run_flow(20);
        await_verdicts();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_flow();
        test_back_to_back();
        test_output_stall();

        await_verdicts();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // A correct run ends well before this timeout, so it only fires on a hang.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
